/* hw/rtl/pf2d_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pareto frontier package
// Shared constants and types of the 2-D Pareto frontier block.
// ----------------------------------------------------------------------------
package pf2d_pkg;
  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 20;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int SIZE_BITS  = 7;
  localparam int SUM_BITS   = 32;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;
endpackage
`default_nettype wire

/* hw/rtl/pareto_frontier_2d_insert.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental 2-D Pareto frontier
// Keeps a staircase of points sorted by x with y falling, one point per x.
// ----------------------------------------------------------------------------
// Input transactions (in_px, in_py, in_new_set) and result transactions
// (out_frontier_size, out_running_total, out_overflow) use valid/ready.
// Each input transaction yields exactly one result transaction.
// The points live in a single-port-read memory with a registered read. A point
// is located by a scan from the lowest entry, one entry per cycle; then the
// entries above are moved by a read-modify-write sweep, each entry read in
// S_MRD and written in S_MWR. A new input is taken only in S_IDLE, which the
// block reaches as the result is presented, so it takes no new item before it
// is through with the last. A new-set item starts from an empty table.
// Reset empties the table and the running sum at once; no clearing pass is
// needed since only entries below the count are ever used.
// The result is held in an output register; while the receiver stalls, the
// block finishes the next item's work only after that register is free.
// ----------------------------------------------------------------------------
module pareto_frontier_2d_insert
  import pf2d_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [COORD_BITS-1:0] in_px,
  input  wire logic [COORD_BITS-1:0] in_py,
  input  wire logic                 in_new_set,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [SIZE_BITS-1:0]      out_frontier_size,
  output logic [SUM_BITS-1:0]       out_running_total,
  output logic                      out_overflow
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_BACK  = 6'b000100,
    S_MRD   = 6'b001000,
    S_MWR   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  coord_t x_r, y_r;
  cnt_t   cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  cnt_t   lo_r, lo_nxt;     // first entry with x >= new x
  cnt_t   j_r, j_nxt;       // first entry removed (y <= new y)
  cnt_t   src_r, src_nxt;   // move source
  cnt_t   dst_r, dst_nxt;   // move destination
  cnt_t   newn_r, newn_nxt;
  logic   ovf_r, ovf_nxt;
  logic   jfound_r, jfound_nxt;
  logic   eqx_r, eqx_nxt;
  logic   ov_r, ov_nxt;
  logic [SIZE_BITS-1:0] osz_r, osz_nxt;
  logic [SUM_BITS-1:0]  osum_r, osum_nxt;
  logic   oovf_r, oovf_nxt;

  logic   we;
  idx_t   waddr, raddr;
  point_t wdata, rdata;
  cnt_t   rd_cnt;

  pf2d_ram u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  assign raddr = rd_cnt[IDX_BITS-1:0];
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_frontier_size = osz_r;
  assign out_running_total = osum_r;
  assign out_overflow = oovf_r;

  // The scan reads entry lo_r each cycle; lo_r is the entry in rdata.
  // While scanning, j tracks the lowest index of a trailing run of y <= new y.
  always_comb begin
    logic [SUM_BITS:0] s;
    logic dominated;
    state_nxt = state_r;
    cnt_nxt = cnt_r; sum_nxt = sum_r;
    lo_nxt = lo_r; j_nxt = j_r; src_nxt = src_r; dst_nxt = dst_r;
    newn_nxt = newn_r; ovf_nxt = ovf_r; jfound_nxt = jfound_r; eqx_nxt = eqx_r;
    ov_nxt = ov_r; osz_nxt = osz_r; osum_nxt = osum_r; oovf_nxt = oovf_r;
    we = 1'b0; waddr = '0; wdata = '0; rd_cnt = lo_r;
    s = '0; dominated = 1'b0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        rd_cnt = '0;
        if (in_valid) begin
          if (in_new_set) begin
            cnt_nxt = '0;
            sum_nxt = '0;
          end
          lo_nxt = '0;
          j_nxt = '0;
          jfound_nxt = 1'b0;
          ovf_nxt = 1'b0;
          eqx_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // rdata holds entry lo_r when lo_r < count
        if (lo_r < cnt_r && rdata.x < x_r) begin
          if (rdata.y <= y_r) begin
            if (!jfound_r) begin
              j_nxt = lo_r;
              jfound_nxt = 1'b1;
            end
          end else begin
            jfound_nxt = 1'b0;
          end
          lo_nxt = lo_r + cnt_t'(1);
          rd_cnt = lo_r + cnt_t'(1);
        end else begin
          dominated = (lo_r < cnt_r) && (rdata.y > y_r);
          if (!jfound_r) begin
            j_nxt = lo_r;
          end
          state_nxt = S_BACK;
          if (dominated) begin
            newn_nxt = cnt_r;
            state_nxt = S_DONE;
          end else if ((lo_r < cnt_r) && (rdata.x == x_r)) begin
            eqx_nxt = 1'b1;
          end
        end
      end
      S_BACK: begin
        // j_r = first removed, lo_r = first kept above
        if (eqx_r) begin
          we = 1'b1;
          waddr = j_r[IDX_BITS-1:0];
          wdata = '{x: x_r, y: y_r};
          newn_nxt = cnt_r - (lo_r - j_r);
          src_nxt = lo_r + cnt_t'(1);
          dst_nxt = j_r + cnt_t'(1);
          state_nxt = (lo_r != j_r) ? S_MRD : S_DONE;
        end else if (lo_r == j_r && cnt_r >= cnt_t'(CAPACITY)) begin
          ovf_nxt = 1'b1;
          newn_nxt = cnt_r;
          state_nxt = S_DONE;
        end else if (lo_r == j_r) begin
          // shift up from the top: src walks down
          newn_nxt = cnt_r + cnt_t'(1);
          src_nxt = cnt_r;
          dst_nxt = cnt_r;
          state_nxt = S_MRD;
        end else begin
          we = 1'b1;
          waddr = j_r[IDX_BITS-1:0];
          wdata = '{x: x_r, y: y_r};
          newn_nxt = cnt_r + cnt_t'(1) - (lo_r - j_r);
          src_nxt = lo_r;
          dst_nxt = j_r + cnt_t'(1);
          state_nxt = (lo_r - j_r == cnt_t'(1)) ? S_DONE : S_MRD;
        end
      end
      S_MRD: begin
        if (!eqx_r && lo_r == j_r) begin
          // upward shift: move entry src-1 to src, down to lo
          if (src_r == lo_r) begin
            we = 1'b1;
            waddr = lo_r[IDX_BITS-1:0];
            wdata = '{x: x_r, y: y_r};
            state_nxt = S_DONE;
          end else begin
            rd_cnt = src_r - cnt_t'(1);
            state_nxt = S_MWR;
          end
        end else if (src_r >= cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          rd_cnt = src_r;
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        we = 1'b1;
        wdata = rdata;
        if (!eqx_r && lo_r == j_r) begin
          waddr = src_r[IDX_BITS-1:0];
          src_nxt = src_r - cnt_t'(1);
        end else begin
          waddr = dst_r[IDX_BITS-1:0];
          src_nxt = src_r + cnt_t'(1);
          dst_nxt = dst_r + cnt_t'(1);
        end
        state_nxt = S_MRD;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          s = {1'b0, sum_r} + (SUM_BITS+1)'(newn_r);
          sum_nxt = s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
          cnt_nxt = newn_r;
          ov_nxt = 1'b1;
          osz_nxt = SIZE_BITS'(newn_r);
          osum_nxt = sum_nxt;
          oovf_nxt = ovf_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      sum_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      x_r <= in_px;
      y_r <= in_py;
    end
    lo_r <= lo_nxt; j_r <= j_nxt; src_r <= src_nxt; dst_r <= dst_nxt;
    newn_r <= newn_nxt; ovf_r <= ovf_nxt; jfound_r <= jfound_nxt; eqx_r <= eqx_nxt;
    osz_r <= osz_nxt; osum_r <= osum_nxt; oovf_r <= oovf_nxt;
  end
endmodule
`default_nettype wire

/* hw/rtl/pf2d_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Pareto frontier point memory
// Single write port, single registered read port holding the sorted points.
// ----------------------------------------------------------------------------
module pf2d_ram
  import pf2d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   we,
  input  wire idx_t   waddr,
  input  wire point_t wdata,
  input  wire idx_t   raddr,
  output point_t      rdata_r
);
  point_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire
